>>> rtl/i2cbm_pkg.sv
package i2cbm_pkg;

    localparam int DATA_BITS_DEF = 8;
    localparam int QUEUE_DEPTH_DEF = 2;
    localparam int CFG_W = 10;
    localparam logic [CFG_W-1:0] ACK_TIMEOUT_RST = 10'd250;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_STOP  = 3'd1;
    localparam logic [2:0] OP_ACK   = 3'd2;
    localparam logic [2:0] OP_NACK  = 3'd3;
    localparam logic [2:0] OP_WACK  = 3'd4;
    localparam logic [2:0] OP_SEND  = 3'd5;
    localparam logic [2:0] OP_READ  = 3'd6;
    localparam logic [2:0] OP_NONE  = 3'd7;

    typedef logic [2:0] t_kind;

    localparam t_kind K_START   = 3'd0;
    localparam t_kind K_STOP    = 3'd1;
    localparam t_kind K_ACK     = 3'd2;
    localparam t_kind K_NACK    = 3'd3;
    localparam t_kind K_WACK_OK = 3'd4;
    localparam t_kind K_WACK_TO = 3'd5;
    localparam t_kind K_SEND    = 3'd6;
    localparam t_kind K_READ    = 3'd7;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_cmd;

endpackage

>>> rtl/i2cbm_cmd_if.sv
interface i2cbm_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] opcode;
    logic [7:0] tx_byte;
    logic [7:0] rx_byte;
    logic [9:0] ack_delay_polls;

    modport source (output valid, output opcode, output tx_byte, output rx_byte,
                    output ack_delay_polls, input ready);
    modport sink (input valid, input opcode, input tx_byte, input rx_byte,
                  input ack_delay_polls, output ready);
endinterface

>>> rtl/i2cbm_phase_if.sv
interface i2cbm_phase_if;
    logic       valid;
    logic       ready;
    logic       scl_level;
    logic       sda_drive;
    logic       sda_level;
    logic [7:0] read_data;
    logic       no_ack;
    logic       last;

    modport source (output valid, output scl_level, output sda_drive, output sda_level,
                    output read_data, output no_ack, output last, input ready);
    modport sink (input valid, input scl_level, input sda_drive, input sda_level,
                  input read_data, input no_ack, input last, output ready);
endinterface

>>> rtl/i2cbm_front.sv
module i2cbm_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [i2cbm_pkg::CFG_W-1:0] i_cfg_wdata,
    i2cbm_cmd_if.sink                   i_cmd,
    input  logic                        i_full,
    output logic                        o_push,
    output i2cbm_pkg::t_cmd             o_entry
);
    import i2cbm_pkg::*;

    logic [CFG_W-1:0] r_ack_timeout;
    logic             accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ack_timeout <= ACK_TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_ack_timeout <= i_cfg_wdata;
        end
    end

    assign i_cmd.ready = !i_full;
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign o_push      = accept && (i_cmd.opcode != OP_NONE);

    always_comb begin
        o_entry.data = (i_cmd.opcode == OP_READ) ? i_cmd.rx_byte : i_cmd.tx_byte;
        case (i_cmd.opcode)
            OP_START: o_entry.kind = K_START;
            OP_STOP:  o_entry.kind = K_STOP;
            OP_ACK:   o_entry.kind = K_ACK;
            OP_NACK:  o_entry.kind = K_NACK;
            OP_WACK:  o_entry.kind = (i_cmd.ack_delay_polls > r_ack_timeout) ?
                                     K_WACK_TO : K_WACK_OK;
            OP_SEND:  o_entry.kind = K_SEND;
            OP_READ:  o_entry.kind = K_READ;
            default:  o_entry.kind = K_START;
        endcase
    end

endmodule

>>> rtl/i2cbm_queue.sv
module i2cbm_queue #(
    parameter int DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  i2cbm_pkg::t_cmd i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output i2cbm_pkg::t_cmd o_head
);
    import i2cbm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> rtl/i2cbm_back.sv
module i2cbm_back #(
    parameter int DATA_BITS = i2cbm_pkg::DATA_BITS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_head_valid,
    input  i2cbm_pkg::t_cmd i_head,
    output logic            o_pop,
    i2cbm_phase_if.source   o_phase
);
    import i2cbm_pkg::*;

    localparam int BIT_W = $clog2(DATA_BITS);

    logic [2:0]       r_step;
    logic [1:0]       r_sub;
    logic [BIT_W-1:0] r_bit;

    logic       r_scl;
    logic       r_sda;
    logic       r_dir;
    logic       r_valid;
    logic [7:0] r_rd;
    logic       r_nak;
    logic       r_last;

    logic             fire;
    logic             ph_dir;
    logic             ph_scl_wr;
    logic             ph_val;
    logic             ph_last;
    logic             bit_end;
    logic [BIT_W-1:0] pos;
    logic             tx_bit;
    logic [1:0]       stop_ph;

    // stop: sda1, scl0, sda0, scl1, sda1 -> {scl_wr, value}
    function automatic logic [1:0] stop_seq(input logic [2:0] idx);
        logic [1:0] r;
        case (idx)
            3'd0:    r = 2'b01;
            3'd1:    r = 2'b10;
            3'd2:    r = 2'b00;
            3'd3:    r = 2'b11;
            default: r = 2'b01;
        endcase
        return r;
    endfunction

    assign bit_end = (r_bit == BIT_W'(DATA_BITS - 1));
    assign pos     = BIT_W'(DATA_BITS - 1) - r_bit;
    assign tx_bit  = ({1'b0, pos} < (BIT_W + 1)'(8)) ? i_head.data[pos[2:0]] : 1'b0;

    always_comb begin
        ph_dir    = 1'b1;
        ph_scl_wr = 1'b0;
        ph_val    = 1'b1;
        ph_last   = 1'b0;
        stop_ph   = 2'b01;
        case (i_head.kind)
            K_START: begin
                ph_scl_wr = r_step[0];
                ph_val    = (r_step < 3'd2);
                ph_last   = (r_step == 3'd3);
            end
            K_STOP: begin
                stop_ph   = stop_seq(r_step);
                ph_scl_wr = stop_ph[1];
                ph_val    = stop_ph[0];
                ph_last   = (r_step == 3'd4);
            end
            K_ACK, K_NACK: begin
                ph_scl_wr = r_step[0] || (r_step == 3'd4);
                case (r_step)
                    3'd0:    ph_val = 1'b1;
                    3'd1:    ph_val = 1'b0;
                    3'd2:    ph_val = (i_head.kind == K_NACK);
                    3'd3:    ph_val = 1'b1;
                    default: ph_val = 1'b0;
                endcase
                ph_last = (r_step == 3'd4);
            end
            K_WACK_OK: begin
                ph_dir    = 1'b0;
                ph_scl_wr = 1'b1;
                ph_val    = (r_step == 3'd0);
                ph_last   = (r_step == 3'd1);
            end
            K_WACK_TO: begin
                if (r_step == 3'd0) begin
                    ph_dir    = 1'b0;
                    ph_scl_wr = 1'b1;
                    ph_val    = 1'b1;
                end else begin
                    stop_ph   = stop_seq(r_step - 3'd1);
                    ph_scl_wr = stop_ph[1];
                    ph_val    = stop_ph[0];
                end
                ph_last = (r_step == 3'd5);
            end
            K_SEND: begin
                if (r_step == 3'd0) begin
                    ph_scl_wr = 1'b1;
                    ph_val    = 1'b0;
                end else begin
                    ph_scl_wr = (r_sub != 2'd0);
                    case (r_sub)
                        2'd0:    ph_val = tx_bit;
                        2'd1:    ph_val = 1'b1;
                        default: ph_val = 1'b0;
                    endcase
                    ph_last = (r_sub == 2'd2) && bit_end;
                end
            end
            default: begin
                // read: slave drives, low then high SCL per bit
                ph_dir    = 1'b0;
                ph_scl_wr = 1'b1;
                ph_val    = r_sub[0];
                ph_last   = r_sub[0] && bit_end;
            end
        endcase
    end

    assign fire  = i_head_valid && (!r_valid || o_phase.ready);
    assign o_pop = fire && ph_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step  <= '0;
            r_sub   <= '0;
            r_bit   <= '0;
            r_scl   <= 1'b1;
            r_sda   <= 1'b1;
            r_dir   <= 1'b1;
            r_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_dir   <= ph_dir;
                if (ph_scl_wr) begin
                    r_scl <= ph_val;
                end else begin
                    r_sda <= ph_val;
                end
                if (ph_last) begin
                    r_step <= '0;
                    r_sub  <= '0;
                    r_bit  <= '0;
                end else begin
                    case (i_head.kind)
                        K_SEND: begin
                            if (r_step == 3'd0) begin
                                r_step <= 3'd1;
                            end else if (r_sub == 2'd2) begin
                                r_sub <= 2'd0;
                                r_bit <= r_bit + 1'b1;
                            end else begin
                                r_sub <= r_sub + 2'd1;
                            end
                        end
                        K_READ: begin
                            if (r_sub[0]) begin
                                r_sub <= 2'd0;
                                r_bit <= r_bit + 1'b1;
                            end else begin
                                r_sub <= 2'd1;
                            end
                        end
                        default: r_step <= r_step + 3'd1;
                    endcase
                end
            end else if (o_phase.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rd   <= (ph_last && (i_head.kind == K_READ)) ? i_head.data : 8'd0;
            r_nak  <= ph_last && (i_head.kind == K_WACK_TO);
            r_last <= ph_last;
        end
    end

    assign o_phase.valid     = r_valid;
    assign o_phase.scl_level = r_scl;
    assign o_phase.sda_drive = r_dir;
    assign o_phase.sda_level = r_sda;
    assign o_phase.read_data = r_rd;
    assign o_phase.no_ack    = r_nak;
    assign o_phase.last      = r_last;

endmodule

>>> rtl/i2c_bitlevel_master.sv
// A command is written into the queue; its first pin phase is then registered at the
// phase output. One pin phase per cycle while the output is not stalled; a command
// has from 2 (wait-ack) to 1 + 3*DATA_BITS phases (send, 25 at 8 bits), set by the
// phase sequencer. A 2-entry command queue decouples the input from the sequencer.
// Reset (synchronous, active low): SCL and SDA released, SDA driven, timeout 250.
module i2c_bitlevel_master #(
    parameter int DATA_BITS   = i2cbm_pkg::DATA_BITS_DEF,
    parameter int QUEUE_DEPTH = i2cbm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [i2cbm_pkg::CFG_W-1:0] i_cfg_wdata,
    i2cbm_cmd_if.sink                   i_cmd,
    i2cbm_phase_if.source               o_phase
);
    import i2cbm_pkg::*;

    logic push;
    logic pop;
    logic full;
    logic head_valid;
    t_cmd entry;
    t_cmd head;

    i2cbm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (i_cmd),
        .i_full      (full),
        .o_push      (push),
        .o_entry     (entry)
    );

    i2cbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head)
    );

    i2cbm_back #(
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_phase      (o_phase)
    );

endmodule

>>> rtl/i2cbm_checker.sv
module i2cbm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       i_ready,
    input logic       i_scl_level,
    input logic       i_sda_drive,
    input logic       i_sda_level,
    input logic [7:0] i_read_data,
    input logic       i_no_ack,
    input logic       i_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_scl_level) && $stable(i_sda_drive)
            && $stable(i_sda_level) && $stable(i_read_data) && $stable(i_last))
        else $error("phase changed while stalled");

    a_nak_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_no_ack |-> i_last && i_scl_level && i_sda_drive && i_sda_level)
        else $error("no-ack phase does not end a stop");

    a_rd_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_read_data != 8'd0) |-> i_last && !i_sda_drive && i_scl_level)
        else $error("read data outside last read phase");

endmodule

bind i2c_bitlevel_master i2cbm_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_phase.valid),
    .i_ready     (o_phase.ready),
    .i_scl_level (o_phase.scl_level),
    .i_sda_drive (o_phase.sda_drive),
    .i_sda_level (o_phase.sda_level),
    .i_read_data (o_phase.read_data),
    .i_no_ack    (o_phase.no_ack),
    .i_last      (o_phase.last)
);
